// File: hw/rtl/crc32_frame_checker_macros.svh
// Assertion macros shared by the frame checker RTL.
`ifndef CRC32_FRAME_CHECKER_MACROS_SVH
`define CRC32_FRAME_CHECKER_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define CRC32FC_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define CRC32FC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/crc32fc_pkg.sv
// Types, constants and the byte-wide CRC function of the frame checker.
package crc32fc_pkg;

    localparam int LINE_DEPTH = 32;
    localparam int FILL_W     = 6;
    localparam int COUNT_W    = 16;
    localparam int CRC_W      = 32;

    localparam logic [CRC_W-1:0]   CRC_POLY   = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0]   CRC_INIT   = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0]   CRC_XOROUT = 32'hFFFF_FFFF;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = 16'hFFFF;

    // Upper seven bits shared by the ASCII characters '0' and '1'
    localparam logic [6:0] CHAR_BIN_HI = 7'h18;

    typedef logic [FILL_W-1:0]  fill_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [CRC_W-1:0]   crc_t;

    typedef enum logic [1:0] {
        STATUS_MATCH    = 2'd0,
        STATUS_MISMATCH = 2'd1,
        STATUS_SHORT    = 2'd2
    } status_t;

    typedef struct packed {
        status_t status;
        count_t  valid_frames;
        crc_t    computed_crc;
    } result_t;

    // Reflected CRC-32 update with one byte
    function automatic crc_t crc32_byte(input crc_t crc, input logic [7:0] data);
        crc_t v;
        v = {24'd0, crc[7:0] ^ data};
        for (int k = 0; k < 8; k++)
        begin
            if (v[0])
            begin
                v = (v >> 1) ^ CRC_POLY;
            end
            else
            begin
                v = v >> 1;
            end
        end
        return (crc >> 8) ^ v;
    endfunction

endpackage

// File: hw/rtl/crc32fc_cell.sv
// One byte cell of the trailer delay line with its checksum-digit compare.
module crc32fc_cell (
    input  logic       clk,
    input  logic       shift_en,
    input  logic [7:0] d_in,
    input  logic       crc_bit,
    output logic [7:0] q,
    output logic       bit_ok
);
    import crc32fc_pkg::*;

    logic [7:0] data_reg;
    logic [7:0] data_next;

    // Take the neighbor's byte on every accepted request
    assign data_next = shift_en ? d_in : data_reg;

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign q = data_reg;

    // Check the incoming byte as the ASCII digit of the expected CRC bit
    assign bit_ok = (d_in == {CHAR_BIN_HI, crc_bit});

endmodule

// File: hw/rtl/crc32fc_crc.sv
// Running CRC-32 register fed by bytes leaving the delay line.
module crc32fc_crc (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic              last,
    input  logic              consume,
    input  logic [7:0]        byte_in,
    output crc32fc_pkg::crc_t crc_final
);
    import crc32fc_pkg::*;

    crc_t crc_reg;
    crc_t crc_next;
    crc_t crc_upd;

    // Fold in the oldest byte once the line is full
    assign crc_upd   = consume ? crc32_byte(crc_reg, byte_in) : crc_reg;
    assign crc_final = crc_upd ^ CRC_XOROUT;

    always_comb
    begin
        crc_next = crc_reg;
        if (accept)
        begin
            crc_next = last ? CRC_INIT : crc_upd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= CRC_INIT;
        end
        else
        begin
            crc_reg <= crc_next;
        end
    end

endmodule

// File: hw/rtl/crc32fc_outbuf.sv
// Two-entry result buffer: output register plus skid register.
module crc32fc_outbuf (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 load,
    input  crc32fc_pkg::result_t load_data,
    input  logic                 out_ready,
    output logic                 out_valid,
    output crc32fc_pkg::result_t out_data,
    output logic                 in_ready
);
    import crc32fc_pkg::*;

    `include "crc32_frame_checker_macros.svh"

    logic    main_valid_reg;
    logic    main_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t main_reg;
    result_t main_next;
    result_t skid_reg;
    result_t skid_next;
    logic    pop;

    assign pop       = main_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    // Advance skid into the output slot, park a new result behind a stall
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = load;
                skid_next       = load_data;
            end
            else
            begin
                main_valid_next = load;
                main_next       = load_data;
            end
        end
        else if (load)
        begin
            skid_valid_next = 1'b1;
            skid_next       = load_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    `CRC32FC_ASSERT(a_skid_behind_main, skid_valid_reg, main_valid_reg, "skid full with empty output")
    `CRC32FC_ASSERT_NEXT(a_stall_holds, main_valid_reg && !out_ready, main_valid_reg && (main_reg == $past(main_reg)), "stalled result changed")

endmodule

// File: hw/rtl/crc32_frame_checker.sv
// Top level of the CRC-32 frame checker: delay line of cells, CRC unit, result buffer.
//
//  port group | dir | tdata                           | tuser        | tlast
//  s_*        | in  | [7:0] data_byte                 | -            | frame_end
//  m_*        | out | [15:0] valid_frames, [47:16] crc | frame_status | -
//
// One byte per cycle while s_tready is high; a frame result is loaded into the result buffer with its last byte.
// The 32-cell delay line shifts each byte; the byte leaving cell 0 updates the CRC.
// Trailer compare, status and count are done in the cycle of the last byte.
// Reset clears the fill count, match count and the result buffer, and loads CRC_INIT; no clearing pass.
// A stalled m_* side holds two results; s_tready drops only when both are waiting.
module crc32_frame_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // frame_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [15:0] valid_frames, [47:16] computed_crc
    output logic [1:0]  m_tuser    // [1:0] frame_status
);
    import crc32fc_pkg::*;

    `include "crc32_frame_checker_macros.svh"

    logic                  in_acc;
    logic [7:0]            line_q [LINE_DEPTH];
    logic [LINE_DEPTH-1:0] bit_ok;
    crc_t                  crc_final;
    fill_t                 fill_reg;
    fill_t                 fill_next;
    count_t                match_count_reg;
    count_t                match_count_next;
    logic                  line_full;
    logic                  full_after;
    logic                  trailer_ok;
    status_t               status;
    result_t               result;
    result_t               out_data;

    assign in_acc     = s_tvalid && s_tready;
    assign line_full  = (fill_reg == FILL_W'(LINE_DEPTH));
    assign full_after = line_full || (fill_reg == FILL_W'(LINE_DEPTH - 1));
    assign trailer_ok = &bit_ok;

    // Delay line: cell i takes cell i+1, the last cell takes the input byte
    for (genvar i = 0; i < LINE_DEPTH; i++)
    begin : g_line
        logic [7:0] d_in;
        if (i == LINE_DEPTH - 1)
        begin : g_tail
            assign d_in = s_tdata;
        end
        else
        begin : g_body
            assign d_in = line_q[i+1];
        end

        crc32fc_cell u_cell (
            .clk      (clk),
            .shift_en (in_acc),
            .d_in     (d_in),
            .crc_bit  (crc_final[CRC_W-1-i]),
            .q        (line_q[i]),
            .bit_ok   (bit_ok[i])
        );
    end

    crc32fc_crc u_crc (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_acc),
        .last      (s_tlast),
        .consume   (line_full),
        .byte_in   (line_q[0]),
        .crc_final (crc_final)
    );

    // Count bytes up to a full line, restart at frame end
    always_comb
    begin
        fill_next = fill_reg;
        if (in_acc)
        begin
            if (s_tlast)
            begin
                fill_next = '0;
            end
            else if (!line_full)
            begin
                fill_next = fill_reg + FILL_W'(1);
            end
        end
    end

    // Classify the frame and bump the saturating match count
    always_comb
    begin
        if (!full_after)
        begin
            status = STATUS_SHORT;
        end
        else if (trailer_ok)
        begin
            status = STATUS_MATCH;
        end
        else
        begin
            status = STATUS_MISMATCH;
        end
    end

    always_comb
    begin
        match_count_next = match_count_reg;
        if (in_acc && s_tlast && (status == STATUS_MATCH) && (match_count_reg != COUNT_MAX))
        begin
            match_count_next = match_count_reg + COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg        <= '0;
            match_count_reg <= '0;
        end
        else
        begin
            fill_reg        <= fill_next;
            match_count_reg <= match_count_next;
        end
    end

    assign result.status       = status;
    assign result.valid_frames = match_count_next;
    assign result.computed_crc = crc_final;

    crc32fc_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_acc && s_tlast),
        .load_data (result),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (out_data),
        .in_ready  (s_tready)
    );

    assign m_tdata = {out_data.computed_crc, out_data.valid_frames};
    assign m_tuser = out_data.status;

    `CRC32FC_ASSERT(a_fill_bound, 1'b1, fill_reg <= FILL_W'(LINE_DEPTH), "fill count above line depth")
    `CRC32FC_ASSERT_NEXT(a_frame_restart, in_acc && s_tlast, fill_reg == '0, "fill count not restarted after frame end")
    `CRC32FC_ASSERT_NEXT(a_count_monotone, 1'b1, match_count_reg >= $past(match_count_reg), "match count decreased")
    `CRC32FC_ASSERT(a_short_zero_crc, m_tvalid && (m_tuser == STATUS_SHORT), m_tdata[47:16] == '0, "short frame with nonzero crc")

endmodule
